// ===== rtl/apm_pkg.sv =====
// Shared constants, types and control structures for the anemometer RPM meter.
// Used by apm_ctrl, apm_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps

package apm_pkg;

  // Field widths.
  localparam int TS_W   = 32;
  localparam int DATA_W = 32;

  // Width over which pulse times wrap, limited to the timestamp field.
  localparam int TIME_WIDTH = 32;
  localparam int TIME_W     = (TIME_WIDTH < TS_W) ? TIME_WIDTH : TS_W;

  // Divider iteration count and counter width.
  localparam int DIV_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 1'd1;

  // Configuration reset values.
  localparam logic [DATA_W-1:0] DEBOUNCE_RST  = 32'd10000;
  localparam logic [DATA_W-1:0] NUMERATOR_RST = 32'd60000000;

  // Input item kinds.
  localparam logic KIND_PULSE   = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Accepted pulses per rotation (third pulse closes two intervals).
  localparam logic [1:0] PULSES_PER_ROT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an input request is taken this cycle
    logic div_step;  // run one restoring division step
    logic load_out;  // copy the quotient into the output register
  } apm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;  // the request on the input closes a rotation
  } apm_sts_t;

endpackage

// ===== rtl/apm_ctrl.sv =====
// Controller for the anemometer RPM meter: sequences item acceptance,
// the bit-serial division and the output handshake. Uses apm_pkg.
`timescale 1ns / 1ps

module apm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  apm_pkg::apm_sts_t sts,
  output apm_pkg::apm_cmd_t cmd
);
  import apm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.need_div) begin
            state_nxt = ST_DIV;
            step_nxt  = '0;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/apm_dp.sv =====
// Datapath for the anemometer RPM meter: configuration registers, pulse
// state, interval accumulation and a restoring bit-serial divider. Uses apm_pkg.
`timescale 1ns / 1ps

module apm_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_kind,
  input  logic [apm_pkg::TS_W-1:0]         in_timestamp_us,
  input  logic                             cfg_valid,
  input  logic [apm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [apm_pkg::DATA_W-1:0]       cfg_data,
  input  apm_pkg::apm_cmd_t                cmd,
  output apm_pkg::apm_sts_t                sts,
  output logic [apm_pkg::DATA_W-1:0]       out_rpm_value
);
  import apm_pkg::*;

  logic [DATA_W-1:0] debounce_r;
  logic [DATA_W-1:0] numerator_r;
  logic [1:0]        count_r;
  logic [TIME_W-1:0] last_r;
  logic [DATA_W-1:0] sum_r;

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] divisor_r;
  logic [DATA_W-1:0] rpm_r;

  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] elapsed;
  logic              bounced;
  logic              take_pulse;
  logic [DATA_W:0]   sum_wide;
  logic [DATA_W-1:0] sum_sat;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  assign now      = in_timestamp_us[TIME_W-1:0];
  assign elapsed  = now - last_r;
  assign bounced  = (count_r != 2'd0) &&
                    ((DATA_W + 1)'(elapsed) <= {1'b0, debounce_r});
  assign take_pulse = (in_kind == KIND_PULSE) && !bounced;
  assign sum_wide = {1'b0, sum_r} + (DATA_W + 1)'(elapsed);
  assign sum_sat  = sum_wide[DATA_W] ? '1 : sum_wide[DATA_W-1:0];

  assign sts.need_div = take_pulse && (count_r == PULSES_PER_ROT);

  // One restoring step; a zero divisor yields an all-ones quotient.
  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  always_comb begin
    if (!diff[DATA_W]) begin
      rem_nxt = diff[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
    end
  end

  assign out_rpm_value = rpm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      numerator_r <= NUMERATOR_RST;
      count_r     <= 2'd0;
      last_r      <= '0;
      sum_r       <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DEBOUNCE:  debounce_r  <= cfg_data;
          CFG_NUMERATOR: numerator_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (in_kind == KIND_RESTART) begin
          count_r <= 2'd0;
        end else if (take_pulse) begin
          last_r <= now;
          if (count_r == PULSES_PER_ROT) begin
            count_r <= 2'd1;
            sum_r   <= '0;
          end else begin
            count_r <= count_r + 2'd1;
            sum_r   <= (count_r == 2'd0) ? '0 : sum_sat;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.need_div) begin
      rem_r     <= '0;
      quo_r     <= numerator_r;
      divisor_r <= sum_sat;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.load_out) begin
      rpm_r <= quo_r;
    end
  end

endmodule

// ===== rtl/anemometer_pulse_rpm_meter_core.sv =====
// Top level of the anemometer pulse-interval RPM meter.
// Instantiates apm_ctrl and apm_dp; uses apm_pkg.
//
// Usage: each input request carries a kind (pulse or restart) and a 32-bit
// microsecond timestamp. Pulses falling at or within the debounce window of
// the last accepted pulse are dropped while a measurement is under way.
// The third accepted pulse of a measurement closes two intervals, and the
// block then returns one result request with rpm = numerator / interval sum.
// Restarts and pulses that do not close a rotation produce no result.
// Sequencing: a request that yields no result is accepted whenever the block
// is idle, and the next request may follow immediately. A request that closes
// a rotation starts a restoring divider that retires one quotient bit per
// cycle over 32 iterations; in_ready stays low until the quotient has been
// loaded into the output register.
// Stalls: the result sits in an output register until taken. If the receiver
// still holds the previous result when a new quotient is ready, the block
// waits with in_ready low until the output register frees up.
// Reset (synchronous, active low) clears the pulse state and returns both
// configuration registers to their defaults. Configuration writes are
// accepted on every cycle and should only be issued while the block is idle.
`timescale 1ns / 1ps

module anemometer_pulse_rpm_meter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [apm_pkg::TS_W-1:0]      in_timestamp_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [apm_pkg::DATA_W-1:0]    out_rpm_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [apm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apm_pkg::DATA_W-1:0]    cfg_data
);
  import apm_pkg::*;

  apm_cmd_t cmd;
  apm_sts_t sts;

  // Configuration registers can always take a write request.
  assign cfg_ready = 1'b1;

  // The controller owns the handshakes and the divider step count.
  apm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the registers, the pulse state and the divider.
  apm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_timestamp_us (in_timestamp_us),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_rpm_value   (out_rpm_value)
  );

`ifndef NO_ASSERTIONS
  // No new request is taken while the divider is running.
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !in_ready)
    else $error("input request accepted during division");

  // A request that closes a rotation holds off the input next cycle.
  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && sts.need_div) |=> (!in_ready && cmd.div_step))
    else $error("division did not start after a closing pulse");

  // A restart request never raises a result in the following cycle.
  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_kind == KIND_RESTART)) |=> !$rose(out_valid))
    else $error("restart produced a result");

  // The output register is only loaded when it is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");
`endif

endmodule

// ===== verif/tb_anemometer_pulse_rpm_meter_core.sv =====
// Self-checking testbench for anemometer_pulse_rpm_meter_core: pulse and restart
// requests against a local debounce/interval/rpm predictor. Depends on apm_pkg and the core.
`timescale 1ns / 1ps

module tb_anemometer_pulse_rpm_meter_core;
  import apm_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  // Margin that covers the division run by a request that closes a rotation.
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [TS_W-1:0] WRAP_MASK = {TS_W{1'b1}} >> (TS_W - TIME_W);

  typedef struct packed {
    logic            kind;
    logic [TS_W-1:0] ts;
  } pulse_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = KIND_PULSE;
  logic [TS_W-1:0]      in_timestamp_us = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DATA_W-1:0]    out_rpm_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [DATA_W-1:0]    cfg_data = '0;

  anemometer_pulse_rpm_meter_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_timestamp_us (in_timestamp_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rpm_value   (out_rpm_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // Requests waiting to be offered, and the rpm values the monitor should see next.
  pulse_req_t        pend_q[$];
  logic [DATA_W-1:0] rpm_exp_q[$];
  pulse_req_t        cur_req;

  // The predictor keeps its own copy of the registers and of the pulse state.
  logic [DATA_W-1:0] debounce_us = DEBOUNCE_RST;
  logic [DATA_W-1:0] numerator = NUMERATOR_RST;
  logic [1:0]        pulses_seen = '0;
  logic [TS_W-1:0]   last_accept_ts = '0;
  logic [DATA_W-1:0] span_sum = '0;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  logic [TS_W-1:0] stim_ts = '0;

  // Applies one accepted request to the predicted state. A pulse that closes a
  // rotation queues the rpm it should produce.
  function automatic void track_pulse(input pulse_req_t req);
    logic [TS_W-1:0]   now;
    logic [TS_W-1:0]   elapsed;
    logic [DATA_W:0]   total;
    logic [DATA_W-1:0] rpm;
    now = req.ts & WRAP_MASK;
    if (req.kind == KIND_RESTART) begin
      pulses_seen = '0;
      return;
    end
    elapsed = (now - last_accept_ts) & WRAP_MASK;
    // Contact bounce: the pulse is dropped only while a measurement is open.
    if (pulses_seen != '0 && elapsed <= debounce_us)
      return;
    if (pulses_seen == '0) begin
      span_sum = '0;
    end else begin
      total = {1'b0, span_sum} + {1'b0, elapsed};
      span_sum = total[DATA_W] ? '1 : total[DATA_W-1:0];
    end
    if (pulses_seen == PULSES_PER_ROT) begin
      rpm = (span_sum == '0) ? '1 : numerator / span_sum;
      rpm_exp_q.push_back(rpm);
      pulses_seen = '0;
      span_sum = '0;
    end
    pulses_seen = pulses_seen + 2'd1;
    last_accept_ts = now;
  endfunction

  // Driver: a new request goes out only once the previous one has been
  // accepted, so valid and the payload stay put while the core stalls. Each
  // signal gets a single assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid)
        track_pulse(cur_req);
      if (pend_q.size() != 0 && $urandom_range(99, 0) >= snd_idle_pct) begin
        cur_req = pend_q.pop_front();
        in_kind <= cur_req.kind;
        in_timestamp_us <= cur_req.ts;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation. A
  // long hold-off is started whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rpm_exp_q.size() == 0) begin
          $error("rpm_value: result with no expectation waiting, actual %0d", out_rpm_value);
          err_count++;
        end else if (out_rpm_value !== rpm_exp_q[0]) begin
          $error("rpm_value mismatch: expected %0d, actual %0d",
                 rpm_exp_q[0], out_rpm_value);
          err_count++;
          void'(rpm_exp_q.pop_front());
        end else begin
          void'(rpm_exp_q.pop_front());
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog for a core that hangs or loses results.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_req(input logic kind, input logic [TS_W-1:0] ts);
    pulse_req_t req;
    req.kind = kind;
    req.ts = ts;
    pend_q.push_back(req);
  endtask

  // Register writes are issued only while the core is idle. The predictor's
  // copy changes at the edge that accepts the write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DEBOUNCE)
      debounce_us = val;
    else
      numerator = val;
    cfg_valid <= 1'b0;
  endtask

  // Waits until every request has been taken and every result has come back,
  // then lets the core settle for the given number of cycles.
  task automatic drain(input int unsigned settle);
    while (pend_q.size() != 0 || in_valid || rpm_exp_q.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Random pulse trains that track a moving time cursor. Most gaps clear the
  // debounce window, so rotations complete. The rest are bounces, gaps equal
  // to the window, wraps of the microsecond counter, near-full gaps that
  // saturate the interval sum, restarts and stray timestamps.
  task automatic queue_random(input int unsigned n);
    int unsigned r;
    logic [63:0] gap;
    pulse_req_t  req;
    repeat (n) begin
      r = $urandom_range(99, 0);
      req.kind = KIND_PULSE;
      if (r < 55)
        gap = 64'(debounce_us) + 64'd1 + 64'($urandom_range(3000, 0));
      else if (r < 65)
        gap = 64'($urandom_range(debounce_us, 0));
      else if (r < 70)
        gap = 64'(debounce_us);
      else if (r < 78)
        gap = 64'($urandom);
      else if (r < 84)
        gap = 64'hFFFF_FFFF - 64'($urandom_range(1000, 0));
      else
        gap = '0;
      if (gap > 64'hFFFF_FFFF)
        gap = 64'hFFFF_FFFF;
      stim_ts = stim_ts + gap[TS_W-1:0];
      req.ts = stim_ts;
      if (r >= 84 && r < 90) begin
        req.kind = KIND_RESTART;
        req.ts = $urandom;
      end else if (r >= 90) begin
        stim_ts = $urandom;
        req.ts = stim_ts;
      end
      pend_q.push_back(req);
    end
  endtask

  // One phase of random traffic. Halfway through, the sender pauses until
  // every expected result has come back.
  task automatic run_phase(input int unsigned n, input int unsigned snd_pct,
                           input int unsigned rcv_pct, input bit long_hold);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    if (long_hold)
      hold_token++;
    queue_random(n / 2);
    drain(0);
    queue_random(n - n / 2);
    drain(DRAIN_CYCLES);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests with the reset register values.
    snd_idle_pct = 25;
    rcv_idle_pct = 51;
    push_req(KIND_RESTART, 32'hFFFF_FFFF);
    push_req(KIND_PULSE, 32'h0000_0000);
    push_req(KIND_PULSE, 32'd5000);      // bounce inside the window
    push_req(KIND_PULSE, 32'd10000);     // exactly on the window edge, still dropped
    push_req(KIND_PULSE, 32'd10001);
    push_req(KIND_PULSE, 32'd30002);     // closes the first rotation
    push_req(KIND_PULSE, 32'hFFFF_FFF0);
    push_req(KIND_PULSE, 32'h0000_5000); // interval spans the counter wrap
    push_req(KIND_PULSE, 32'h0000_4F00); // almost a full wrap
    push_req(KIND_PULSE, 32'h0000_4E00); // interval sum saturates
    push_req(KIND_PULSE, 32'h0001_0000);
    push_req(KIND_RESTART, 32'h0000_0000);
    push_req(KIND_PULSE, 32'h0001_0010); // first pulse after a restart is never debounced
    push_req(KIND_PULSE, 32'h0002_0000);
    push_req(KIND_RESTART, 32'h1234_5678);
    push_req(KIND_PULSE, 32'hAAAA_AAAA);
    push_req(KIND_PULSE, 32'h5555_5555);
    push_req(KIND_PULSE, 32'h5555_8000);
    push_req(KIND_PULSE, 32'h5556_0000);
    stim_ts = 32'h5556_0000;
    drain(DRAIN_CYCLES);

    // The first random phase also includes the long receiver hold-off.
    run_phase(150, 25, 51, 1'b1);

    write_reg(CFG_DEBOUNCE, '0);
    write_reg(CFG_NUMERATOR, 32'd1);
    run_phase(100, 25, 51, 1'b0);

    // With the widest window every pulse is a bounce while a measurement is open.
    write_reg(CFG_DEBOUNCE, '1);
    write_reg(CFG_NUMERATOR, '1);
    run_phase(20, 51, 25, 1'b0);

    write_reg(CFG_DEBOUNCE, $urandom_range(5000, 0));
    write_reg(CFG_NUMERATOR, '0);
    run_phase(70, 51, 25, 1'b0);

    write_reg(CFG_DEBOUNCE, DEBOUNCE_RST);
    write_reg(CFG_NUMERATOR, '1);
    run_phase(150, 51, 25, 1'b0);

    write_reg(CFG_DEBOUNCE, $urandom_range(200000, 0));
    write_reg(CFG_NUMERATOR, $urandom);
    run_phase(200, 0, 0, 1'b0);

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
